/* rtl/cwc_pkg.sv */
package cwc_pkg;

  // Table geometry
  localparam int MAX_AMOUNT  = 255;
  localparam int TABLE_DEPTH = MAX_AMOUNT + 1;
  localparam int AW          = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int COUNT_W = 64;
  localparam int COIN_W  = 8;
  localparam int TGT_W   = 8;

  localparam logic [7:0] TARGET_RESET = 8'd200;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [AW-1:0]      addr_t;
  typedef logic [COIN_W-1:0]  coin_t;
  typedef logic [TGT_W-1:0]   tgt_t;

  localparam count_t COUNT_MAX = '1;

endpackage

/* rtl/cwc_ifs.sv */
interface cwc_in_if;
  import cwc_pkg::*;
  logic  valid;
  logic  ready;
  coin_t coin_value;
  logic  first_coin;
  modport source (output valid, output coin_value, output first_coin, input ready);
  modport sink   (input valid, input coin_value, input first_coin, output ready);
endinterface

interface cwc_out_if;
  import cwc_pkg::*;
  logic   valid;
  logic   ready;
  count_t ways;
  logic   saturated;
  modport source (output valid, output ways, output saturated, input ready);
  modport sink   (input valid, input ways, input saturated, output ready);
endinterface

interface cwc_cfg_if;
  import cwc_pkg::*;
  logic valid;
  logic ready;
  tgt_t target_amount;
  modport source (output valid, output target_amount, input ready);
  modport sink   (input valid, input target_amount, output ready);
endinterface

/* rtl/cwc_ram.sv */
module cwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/coin_change_way_counter.sv */
// Coin change way counter. Each input beat adds one coin denomination to the
// set and returns one result beat: the number of combinations (coins reusable
// without limit) that make the configured target amount, saturating at
// 2^64-1, plus a sticky flag that is set once any table entry reached that
// limit. A beat with first_coin set starts a new set: the table is reset to
// one way for amount 0 and none elsewhere and the flag is cleared. The block
// takes one beat at a time. A coin c in 1..255 sweeps table entries c..255
// through a single saturating 64-bit adder, one entry per cycle; then the
// target entry is read into the output register. Coin 0 skips the sweep.
// The sweep rate is set by the one write port of the table RAM. The input is
// ready again as soon as the result is loaded into the output register, even
// if that result has not yet been taken. target_amount may be written any
// time the block is idle; the config channel is always ready.
module coin_change_way_counter (
  input logic     clk,
  input logic     rst_n,
  cwc_in_if.sink   in_ch,
  cwc_out_if.source out_ch,
  cwc_cfg_if.sink  cfg_ch
);
  import cwc_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0; // waiting for a coin
  localparam logic [2:0] ST_SWEEP = 3'd1; // issuing reads for entries j
  localparam logic [2:0] ST_DRAIN = 3'd2; // last entry being written
  localparam logic [2:0] ST_FETCH = 3'd3; // read target entry
  localparam logic [2:0] ST_LOAD  = 3'd4; // move count into output register

  logic [2:0] state_r, state_nxt;
  coin_t      coin_r, coin_nxt;
  addr_t      j_r, j_nxt;
  tgt_t       target_r;

  // Per-entry valid bits: an entry never written since the last clear reads
  // as its reset value (1 at amount 0, else 0).
  logic [TABLE_DEPTH-1:0] vld_r;
  logic                   sat_seen_r;

  // Stage 2 of the sweep: data for entry j and j-coin arrives from the RAM.
  logic   s1_valid_r;
  addr_t  s1_addr_r;
  logic   s1_va_r;      // entry j valid when read
  logic   s1_vb_r;      // entry j-coin valid when read
  logic   s1_bzero_r;   // j-coin is amount 0
  logic   s1_fwd_r;     // coin 1: j-1 is the sum written last cycle
  count_t last_sum_r;
  logic   f_vld_r;      // target entry valid at fetch

  logic   out_valid_r;
  count_t out_ways_r;
  logic   out_sat_r;

  // RAM connections
  logic   ram_we;
  addr_t  ram_raddr_a, ram_raddr_b;
  count_t ram_rdata_a, ram_rdata_b;
  count_t ram_wdata;

  logic in_fire, out_fire, coin_ok, tgt_ok;

  // Saturating adder, shared by every entry of the sweep
  count_t           add_a, add_b;
  logic [COUNT_W:0] add_sum;
  logic             add_hit;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ways      = out_ways_r;
  assign out_ch.saturated = out_sat_r;

  assign coin_ok = (in_ch.coin_value != '0) && (int'(in_ch.coin_value) <= MAX_AMOUNT);
  assign tgt_ok  = (int'(target_r) <= MAX_AMOUNT);

  // Operands: entry j plus entry j-coin; coin 1 takes j-1 from the adder's
  // own last result since the RAM write of that entry lands on this edge.
  assign add_a   = s1_va_r ? ram_rdata_a : '0;
  assign add_b   = s1_fwd_r ? last_sum_r :
                   s1_vb_r  ? ram_rdata_b :
                   (s1_bzero_r ? count_t'(1) : '0);
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_hit = add_sum[COUNT_W] || (add_sum[COUNT_W-1:0] == COUNT_MAX);
  assign ram_wdata = add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];
  assign ram_we    = s1_valid_r;

  always_comb begin
    ram_raddr_a = j_r;
    if (state_r == ST_FETCH || state_r == ST_LOAD) begin
      ram_raddr_a = addr_t'(target_r);
    end
  end
  assign ram_raddr_b = j_r - addr_t'(coin_r);

  cwc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s1_addr_r),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    coin_nxt  = coin_r;
    j_nxt     = j_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          coin_nxt = in_ch.coin_value;
          j_nxt    = addr_t'(in_ch.coin_value);
          state_nxt = coin_ok ? ST_SWEEP : ST_FETCH;
        end
      end
      ST_SWEEP: begin
        if (int'(j_r) == MAX_AMOUNT) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + addr_t'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= TARGET_RESET;
      vld_r       <= '0;
      sat_seen_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= (state_r == ST_SWEEP);
      if (cfg_ch.valid) begin
        target_r <= cfg_ch.target_amount;
      end
      if (in_fire && in_ch.first_coin) begin
        vld_r      <= '0;
        sat_seen_r <= 1'b0;
      end else if (s1_valid_r) begin
        vld_r[s1_addr_r] <= 1'b1;
        if (add_hit) begin
          sat_seen_r <= 1'b1;
        end
      end
      if (state_r == ST_LOAD && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    coin_r     <= coin_nxt;
    j_r        <= j_nxt;
    s1_addr_r  <= j_r;
    s1_va_r    <= vld_r[j_r];
    s1_vb_r    <= vld_r[ram_raddr_b];
    s1_bzero_r <= (ram_raddr_b == '0);
    s1_fwd_r   <= (coin_r == coin_t'(1)) && (j_r != addr_t'(coin_r));
    if (s1_valid_r) begin
      last_sum_r <= ram_wdata;
    end
    if (state_r == ST_FETCH) begin
      f_vld_r <= vld_r[addr_t'(target_r)];
    end
    if (state_r == ST_LOAD && (!out_valid_r || out_ch.ready)) begin
      out_sat_r <= sat_seen_r;
      if (!tgt_ok) begin
        out_ways_r <= '0;
      end else if (f_vld_r) begin
        out_ways_r <= ram_rdata_a;
      end else begin
        out_ways_r <= (target_r == '0) ? count_t'(1) : '0;
      end
    end
  end

endmodule

/* rtl/cwc_checker.sv */
module cwc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input cwc_pkg::count_t ways,
  input logic            saturated
);
  import cwc_pkg::*;

  // One coin at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // A new result only appears after the block was busy
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

  // Count at the limit implies the sticky flag
  a_max_flags_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (ways == COUNT_MAX)) |-> saturated)
    else $error("saturated count without flag");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(ways) && $stable(saturated)))
    else $error("stalled result changed");

endmodule

bind coin_change_way_counter cwc_checker u_cwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .ways      (out_ch.ways),
  .saturated (out_ch.saturated)
);
